// ----- rtl/core/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes of the software timer table
// Request and result layouts, command and status codes, and the command
// bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package stt_pkg;

    // command codes
    localparam logic [1:0] CMD_ONESHOT  = 2'd0;
    localparam logic [1:0] CMD_PERIODIC = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;
    localparam logic [1:0] CMD_RUN      = 2'd3;

    // status codes
    localparam logic [2:0] ST_SCHEDULED = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_FIRED     = 3'd3;
    localparam logic [2:0] ST_WAIT      = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    // largest reported wait
    localparam logic [30:0] WAIT_MAX = '1;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] now_ms;
        logic [31:0] span_ms;
        logic [31:0] target_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_id;
        logic [30:0] wait_ms;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the request, clear scan results
        logic rd_en;    // read the slot at the scan address
        logic finish;   // write the result and update the table
    } t_ctl_cmd;

endpackage

// ----- rtl/core/stt_ctrl.sv -----
// ----------------------------------------------------------------------------
// stt_ctrl: sequencer of the software timer table
// Takes one request, walks the slot memory one address a cycle, then waits
// for room in the result register and issues the finish step.
// ----------------------------------------------------------------------------
module stt_ctrl
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_free,
    output t_ctl_cmd      o_ctl,
    output logic [IW-1:0] o_rd_addr
);

    localparam int CW = $clog2(TIMER_SLOTS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          scan_last;

    assign scan_last = (r_idx == CW'(TIMER_SLOTS));

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_ctl.load   = 1'b0;
        o_ctl.rd_en  = 1'b0;
        o_ctl.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // last read data is evaluated in the cycle after the last read
                if (scan_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_addr  = r_idx[IW-1:0];

endmodule

// ----- rtl/core/stt_dpath.sv -----
// ----------------------------------------------------------------------------
// stt_dpath: slot storage and scan logic of the software timer table
// Holds the slot memories and valid bits, tracks free, matching and earliest
// slots during a scan, and builds the result and table update at the end.
// ----------------------------------------------------------------------------
module stt_dpath
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_in_item      i_in_data,
    input  t_ctl_cmd      i_ctl,
    input  logic [IW-1:0] i_rd_addr,
    input  logic          i_out_stall,
    output logic          o_out_free,
    output logic          o_out_valid,
    output t_out_item     o_out_data
);

    // slot memories
    logic [31:0] mem_id  [TIMER_SLOTS];
    logic [47:0] mem_due [TIMER_SLOTS];
    logic [31:0] mem_per [TIMER_SLOTS];

    logic [TIMER_SLOTS-1:0] r_valid;
    logic [31:0]            r_next_id;
    t_in_item               r_item;

    // read stage
    logic          r_rd_en;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic [31:0]   r_rd_id;
    logic [47:0]   r_rd_due;
    logic [31:0]   r_rd_per;

    // scan results
    logic          r_same_hit, r_free_hit, r_best_hit;
    logic [IW-1:0] r_same_idx, r_free_idx, r_best_idx;
    logic [47:0]   r_best_due;
    logic [31:0]   r_best_id;
    logic [31:0]   r_best_per;

    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          is_sched, is_cancel, is_run;
    logic          take_same, take_free, take_best, cancel_hit;
    logic          pick_hit;
    logic [IW-1:0] pick_idx;
    logic [48:0]   sched_sum, rearm_sum;
    logic [47:0]   sched_due, rearm_due;
    logic          is_due;
    logic [47:0]   diff;
    logic [30:0]   wait_val;
    logic          do_sched, do_fire, do_rearm, do_free;
    logic [IW-1:0] due_addr;
    logic [47:0]   due_data;
    t_out_item     n_out;

    assign is_sched  = (r_item.command == CMD_ONESHOT) || (r_item.command == CMD_PERIODIC);
    assign is_cancel = (r_item.command == CMD_CANCEL);
    assign is_run    = (r_item.command == CMD_RUN);

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_in_data;
        end
    end

    // registered memory read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_idx <= i_rd_addr;
            r_rd_vld <= r_valid[i_rd_addr];
            r_rd_id  <= mem_id[i_rd_addr];
            r_rd_due <= mem_due[i_rd_addr];
            r_rd_per <= mem_per[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= i_ctl.rd_en;
        end
    end

    // per-slot evaluation of the read data
    assign take_same  = r_rd_en && is_sched && r_rd_vld && (r_rd_id == r_next_id) && !r_same_hit;
    assign take_free  = r_rd_en && is_sched && !r_rd_vld && !r_free_hit;
    assign take_best  = r_rd_en && is_run && r_rd_vld &&
                        (!r_best_hit || (r_rd_due < r_best_due) ||
                         ((r_rd_due == r_best_due) && (r_rd_id < r_best_id)));
    assign cancel_hit = r_rd_en && is_cancel && r_rd_vld && (r_rd_id == r_item.target_id);

    // scan flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_same_hit <= 1'b0;
            r_free_hit <= 1'b0;
            r_best_hit <= 1'b0;
        end else if (i_ctl.load) begin
            r_same_hit <= 1'b0;
            r_free_hit <= 1'b0;
            r_best_hit <= 1'b0;
        end else begin
            if (take_same) r_same_hit <= 1'b1;
            if (take_free) r_free_hit <= 1'b1;
            if (take_best) r_best_hit <= 1'b1;
        end
    end

    // scan payload
    always_ff @(posedge i_clk) begin
        if (take_same) begin
            r_same_idx <= r_rd_idx;
        end
        if (take_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (take_best) begin
            r_best_idx <= r_rd_idx;
            r_best_due <= r_rd_due;
            r_best_id  <= r_rd_id;
            r_best_per <= r_rd_per;
        end
    end

    // finish step: schedule target and saturating due times
    assign pick_hit  = r_same_hit || r_free_hit;
    assign pick_idx  = r_same_hit ? r_same_idx : r_free_idx;
    assign sched_sum = {1'b0, r_item.now_ms} + {17'd0, r_item.span_ms};
    assign sched_due = sched_sum[48] ? '1 : sched_sum[47:0];
    assign rearm_sum = {1'b0, r_best_due} + {17'd0, r_best_per};
    assign rearm_due = rearm_sum[48] ? '1 : rearm_sum[47:0];

    // finish step: due check and saturated wait
    assign is_due   = (r_best_due <= r_item.now_ms);
    assign diff     = r_best_due - r_item.now_ms;
    assign wait_val = (diff > {17'd0, WAIT_MAX}) ? WAIT_MAX : diff[30:0];

    assign do_sched = i_ctl.finish && is_sched && pick_hit;
    assign do_fire  = i_ctl.finish && is_run && r_best_hit && is_due;
    assign do_rearm = do_fire && (r_best_per != 32'd0);
    assign do_free  = do_fire && (r_best_per == 32'd0);
    assign due_addr = do_sched ? pick_idx : r_best_idx;
    assign due_data = do_sched ? sched_due : rearm_due;

    // memory writes
    always_ff @(posedge i_clk) begin
        if (do_sched || do_rearm) begin
            mem_due[due_addr] <= due_data;
        end
        if (do_sched) begin
            mem_id[pick_idx]  <= r_next_id;
            mem_per[pick_idx] <= (r_item.command == CMD_PERIODIC) ? r_item.span_ms : 32'd0;
        end
    end

    // valid bits and id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next_id <= '0;
        end else begin
            if (cancel_hit) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
            if (do_sched) begin
                r_valid[pick_idx] <= 1'b1;
                r_next_id         <= r_next_id + 32'd1;
            end
            if (do_free) begin
                r_valid[r_best_idx] <= 1'b0;
            end
        end
    end

    // result decode
    always_comb begin
        n_out = '0;
        unique case (r_item.command) inside
            CMD_ONESHOT, CMD_PERIODIC: begin
                if (pick_hit) begin
                    n_out.status    = ST_SCHEDULED;
                    n_out.result_id = r_next_id;
                end else begin
                    n_out.status    = ST_FULL;
                end
            end
            CMD_CANCEL: begin
                n_out.status = ST_CANCELLED;
            end
            CMD_RUN: begin
                if (!r_best_hit) begin
                    n_out.status = ST_NONE;
                end else if (!is_due) begin
                    n_out.status  = ST_WAIT;
                    n_out.wait_ms = wait_val;
                end else begin
                    n_out.status    = ST_FIRED;
                    n_out.result_id = r_best_id;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/software_timer_table.sv -----
// ----------------------------------------------------------------------------
// software_timer_table: table of one-shot and periodic timers
// Schedules, cancels and fires timers held in TIMER_SLOTS slots.
// ----------------------------------------------------------------------------
// Each request (schedule, cancel or run) goes through a scan, which reads one
// slot per cycle from the single read port of the slot memory, then the
// evaluation of the last registered read, the table update, and the idle
// state in which the next request is taken. One request is worked on at a
// time; the result waits in an output register, so a new request is taken
// while the previous result is still stalled, and only the final update step
// waits for that register to empty. Valid bits are cleared by reset; no
// clearing pass.
// ----------------------------------------------------------------------------
module software_timer_table
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    t_ctl_cmd      ctl;
    logic [IW-1:0] rd_addr;
    logic          out_free;

    // sequencer
    stt_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .IW          (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_rd_addr  (rd_addr)
    );

    // slot storage and scan
    stt_dpath #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .IW          (IW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (ctl),
        .i_rd_addr   (rd_addr),
        .i_out_stall (i_out_stall),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/stt_checker.sv -----
// ----------------------------------------------------------------------------
// stt_checker: port-level checks of the software timer table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // a request is worked on alone: the next cycle is busy
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while scan in progress");

    // wait time shows only, and always, with wait status
    a_wait_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == ST_WAIT) == (o_out_data.wait_ms != '0)))
        else $error("wait field inconsistent with status");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
